// File: hw/rtl/sesa_pkg.sv
// ----------------------------------------------------------------------------
// sesa_pkg
// shared constants and types for the scanline edge span accumulator
// ----------------------------------------------------------------------------
package sesa_pkg;

  localparam int ROWS    = 200;
  localparam int COLUMNS = 320;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int X_W     = 16;

  typedef enum logic [1:0] {
    CMD_HSPAN = 2'd0,
    CMD_VSPAN = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  // broadcast widen request, row range is already clamped
  typedef struct packed {
    logic                  en;
    logic signed [X_W-1:0] lo;
    logic signed [X_W-1:0] hi;
    logic signed [X_W-1:0] xl;
    logic signed [X_W-1:0] xr;
  } widen_t;

  // drain request: read and empty one row
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } drain_t;

  // edge pair travelling down the chain
  typedef struct packed {
    logic                  tok;
    logic signed [X_W-1:0] left;
    logic signed [X_W-1:0] right;
  } chain_t;

endpackage

// File: hw/rtl/sesa_cell.sv
// ----------------------------------------------------------------------------
// sesa_cell
// one row of the edge table plus one stage of the readout chain
// ----------------------------------------------------------------------------
module sesa_cell
  import sesa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [ROW_W-1:0] row_id,
  input  widen_t           widen,
  input  drain_t           drain,
  input  chain_t           chain_in,
  output chain_t           chain_out
);

  logic signed [X_W-1:0] left;
  logic signed [X_W-1:0] right;
  logic signed [X_W-1:0] row_s;
  logic                  hit_w;
  logic                  hit_d;

  assign row_s = $signed({{(X_W-ROW_W){1'b0}}, row_id});
  assign hit_w = widen.en && (row_s >= widen.lo) && (row_s <= widen.hi);
  assign hit_d = drain.en && (drain.row == row_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      left          <= X_W'(COLUMNS);
      right         <= '1;
      chain_out.tok <= 1'b0;
    end else begin
      if (hit_d) begin
        left      <= X_W'(COLUMNS);
        right     <= '1;
        chain_out <= '{tok: 1'b1, left: left, right: right};
      end else begin
        chain_out <= chain_in;
        if (hit_w) begin
          if (left > widen.xl) left <= widen.xl;
          if (right < widen.xr) right <= widen.xr;
        end
      end
    end
  end

endmodule

// File: hw/rtl/scanline_edge_span_accumulator_core.sv
// ----------------------------------------------------------------------------
// scanline_edge_span_accumulator_core
// per-row edge table in a chain of cells, drained one row per beat
// ----------------------------------------------------------------------------
//  channel | signals                                       | direction
//  in      | in_valid in_stall command x_start x_end       | into block
//          | y_start y_end                                 |
//  out     | out_valid out_stall span_left span_right      | out of block
//          | span_row span_valid last                      |
//
// span beats are applied by the cells, which widen all rows in parallel
// a drain beat empties its row; the row's edges ride the
// readout chain one cell per cycle to the tail
// reset (rst, synchronous) empties every row and the touched-row bounds
// at once; a result waiting under out_stall holds the next drain
module scanline_edge_span_accumulator_core
  import sesa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] x_start,
  input  logic [15:0] x_end,
  input  logic [15:0] y_start,
  input  logic [15:0] y_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  span_left,
  output logic [8:0]  span_right,
  output logic [7:0]  span_row,
  output logic        span_valid,
  output logic        last
);

  state_t           state;
  state_t           state_next;
  logic [ROW_W-1:0] lowest;
  logic [ROW_W-1:0] highest;
  logic [ROW_W-1:0] cursor;
  logic             draining;
  logic signed [X_W-1:0] cap_left;
  logic signed [X_W-1:0] cap_right;

  logic                  accept;
  logic                  out_free;
  logic signed [X_W-1:0] xs, xe, ys, ye;
  logic signed [X_W-1:0] v_lo, v_hi;
  logic                  h_ok, v_ok;
  logic                  empty;
  logic [ROW_W-1:0]      drain_row;
  widen_t                widen;
  drain_t                drain;
  chain_t                chain [ROWS+1];
  logic signed [X_W-1:0] clip_l, clip_r;
  logic                  clip_ok;
  logic                  fin;

  assign xs = $signed(x_start);
  assign xe = $signed(x_end);
  assign ys = $signed(y_start);
  assign ye = $signed(y_end);

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign h_ok  = (ys >= 0) && (ys <= X_W'(ROWS - 1));
  assign v_lo  = (ys < 0) ? '0 : ys;
  assign v_hi  = (ye > X_W'(ROWS - 1)) ? X_W'(ROWS - 1) : ye;
  assign v_ok  = (v_lo <= v_hi);
  assign empty = lowest > highest;
  assign drain_row = draining ? cursor : lowest;

  assign clip_l  = (cap_left < 0) ? '0 : cap_left;
  assign clip_r  = (cap_right > X_W'(COLUMNS - 1)) ? X_W'(COLUMNS - 1) : cap_right;
  assign clip_ok = clip_l <= clip_r;
  assign fin     = cursor >= highest;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_DRAIN && (draining || !empty)) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (chain[ROWS].tok) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs to the handshake and the cells
  always_comb begin
    in_stall = (state != ST_IDLE);
    widen    = '{en: 1'b0, lo: ys, hi: ys, xl: xs, xr: xe};
    drain    = '{en: 1'b0, row: drain_row};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_HSPAN: widen.en = h_ok;
            CMD_VSPAN: widen = '{en: v_ok, lo: v_lo, hi: v_hi, xl: xs, xr: xs};
            CMD_DRAIN: drain.en = draining || !empty;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign chain[0] = '{tok: 1'b0, left: '0, right: '0};

  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    sesa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .row_id    (ROW_W'(i)),
      .widen     (widen),
      .drain     (drain),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lowest    <= ROW_W'(ROWS - 1);
      highest   <= '0;
      cursor    <= '0;
      draining  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a beat leaving the output is refilled in the same cycle by emit
      if (out_valid && !out_stall && state != ST_EMIT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command)
              CMD_HSPAN: begin
                if (h_ok) begin
                  if (ROW_W'(ys) < lowest) lowest <= ROW_W'(ys);
                  if (ROW_W'(ys) > highest) highest <= ROW_W'(ys);
                end
              end
              CMD_VSPAN: begin
                if (v_ok) begin
                  if (ROW_W'(v_lo) < lowest) lowest <= ROW_W'(v_lo);
                  if (ROW_W'(v_hi) > highest) highest <= ROW_W'(v_hi);
                end
              end
              CMD_DRAIN: begin
                if (!draining && empty) begin
                  lowest  <= ROW_W'(ROWS - 1);
                  highest <= '0;
                end else begin
                  cursor   <= drain_row;
                  draining <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SWEEP: begin
          if (chain[ROWS].tok) begin
            cap_left  <= chain[ROWS].left;
            cap_right <= chain[ROWS].right;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            span_left  <= clip_ok ? clip_l[8:0] : '0;
            span_right <= clip_ok ? clip_r[8:0] : '0;
            span_row   <= 8'(cursor);
            span_valid <= clip_ok;
            last       <= fin;
            if (fin) begin
              draining <= 1'b0;
              lowest   <= ROW_W'(ROWS - 1);
              highest  <= '0;
            end else begin
              cursor <= cursor + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    draining |-> cursor <= highest)
    else $error("drain cursor past highest row");

  a_tok_in_sweep: assert property (@(posedge clk) disable iff (rst)
    chain[ROWS].tok |-> state == ST_SWEEP)
    else $error("chain token outside sweep");

  a_span_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && span_valid) |-> span_left <= span_right)
    else $error("span left past right");

  a_sweep_draining: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> draining)
    else $error("sweep without drain pass");

endmodule

// File: dv/span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// span_checker
// watches both channels of the span accumulator, tracks the edge table and
// compares every drained row against the expected span
// ----------------------------------------------------------------------------
module span_checker
  import sesa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] x_start,
  input  logic [15:0] x_end,
  input  logic [15:0] y_start,
  input  logic [15:0] y_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [8:0]  span_left,
  input  logic [8:0]  span_right,
  input  logic [7:0]  span_row,
  input  logic        span_valid,
  input  logic        last,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [8:0] left;
    logic [8:0] right;
    logic [7:0] row;
    logic       ok;
    logic       fin;
  } span_t;

  int    row_left [ROWS];
  int    row_right[ROWS];
  int    low_row, high_row, cursor;
  bit    in_pass;
  span_t spans_due[$];

  function automatic void clear_table();
    for (int i = 0; i < ROWS; i++) begin
      row_left[i]  = COLUMNS;
      row_right[i] = -1;
    end
    low_row  = ROWS - 1;
    high_row = 0;
    cursor   = 0;
    in_pass  = 0;
  endfunction

  function automatic void touch_row(int r, int xl, int xr);
    if (r < 0 || r >= ROWS) return;
    if (r < low_row) low_row = r;
    if (r > high_row) high_row = r;
    if (row_left[r] > xl) row_left[r] = xl;
    if (row_right[r] < xr) row_right[r] = xr;
  endfunction

  // applies one input beat to the table, queues a span if a row is drained
  function automatic void apply_beat(logic [1:0] cmd, int xs, int xe, int ys, int ye);
    int    l, r, cur;
    span_t s;
    case (cmd)
      CMD_HSPAN: begin
        touch_row(ys, xs, xe);
      end
      CMD_VSPAN: begin
        if (ys < 0) ys = 0;
        if (ye > ROWS - 1) ye = ROWS - 1;
        for (int k = ys; k <= ye; k++) touch_row(k, xs, xs);
      end
      CMD_DRAIN: begin
        if (!in_pass) begin
          if (low_row > high_row) begin
            low_row  = ROWS - 1;
            high_row = 0;
            return;
          end
          cursor  = low_row;
          in_pass = 1;
        end
        cur = cursor;
        l = row_left[cur];
        r = row_right[cur];
        if (l < 0) l = 0;
        if (r > COLUMNS - 1) r = COLUMNS - 1;
        s.ok    = (l <= r);
        s.left  = s.ok ? l[8:0] : '0;
        s.right = s.ok ? r[8:0] : '0;
        s.row   = cur[7:0];
        row_left[cur]  = COLUMNS;
        row_right[cur] = -1;
        s.fin = (cur >= high_row);
        if (s.fin) begin
          in_pass  = 0;
          low_row  = ROWS - 1;
          high_row = 0;
        end else begin
          cursor = cur + 1;
        end
        spans_due.push_back(s);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    span_t want, got;
    if (rst) begin
      clear_table();
      spans_due.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{span_left, span_right, span_row, span_valid, last};
        if (spans_due.size() == 0) begin
          $display("%0t: span beat with none expected: actual %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = spans_due.pop_front();
          if (got !== want) begin
            $display("%0t: span mismatch: expected %p actual %p", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        apply_beat(command, $signed(x_start), $signed(x_end),
                   $signed(y_start), $signed(y_end));
      pending <= spans_due.size();
    end
  end

endmodule

// File: dv/tb_scanline_edge_span_accumulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scanline_edge_span_accumulator_core
// drives edge spans and drain passes with random idling on both channels;
// the span checker predicts and compares every drained row
// ----------------------------------------------------------------------------
module tb_scanline_edge_span_accumulator_core
  import sesa_pkg::*;
();

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  command;
  logic [15:0] x_start, x_end, y_start, y_end;
  logic [8:0]  span_left, span_right;
  logic [7:0]  span_row;
  logic        span_valid, last;
  int          errors, pending;
  int          send_idle, recv_idle, sent;

  scanline_edge_span_accumulator_core DUT (.*);
  span_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else     out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send(logic [1:0] cmd, int xs, int xe, int ys, int ye);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command  <= cmd;
    x_start  <= xs[15:0];
    x_end    <= xe[15:0];
    y_start  <= ys[15:0];
    y_end    <= ye[15:0];
    do @(posedge clk); while (in_stall);
    sent++;
    if (sent == 450) begin send_idle = 45; recv_idle = 38; end
    if (sent == 900) begin send_idle = 0;  recv_idle = 0;  end
  endtask

  // one shape: a few edges around a base row, then a drain pass
  task automatic shape();
    int base, h, n;
    base = $urandom_range(0, ROWS - 1);
    h    = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    n    = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0)
        send(CMD_VSPAN, $urandom_range(0, 400) - 40, $urandom,
             base + $urandom_range(0, h) - 1, base + $urandom_range(0, h) + 1);
      else
        send(CMD_HSPAN, $urandom_range(0, 400) - 40, $urandom_range(0, 400) - 40,
             base + $urandom_range(0, h + 1) - 1, $urandom);
    end
    // sometimes stop early so the next pass picks up from the cursor
    n = ($urandom_range(4) == 0) ? $urandom_range(1, h + 1) : h + 4;
    for (int i = 0; i < n; i++) send(CMD_DRAIN, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    rst = 1; in_valid = 0; out_stall = 0;
    command = CMD_HSPAN; x_start = 0; x_end = 0; y_start = 0; y_end = 0;
    send_idle = 38; recv_idle = 45; sent = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: extremes, off-screen rows, clamps, empty drain, unused code
    send(CMD_DRAIN, 0, 0, 0, 0);
    send(CMD_HSPAN, -32768, 32767, -1, 0);
    send(CMD_HSPAN, -32768, 32767, ROWS, 0);
    send(CMD_HSPAN, -32768, 32767, -32768, 0);
    send(CMD_HSPAN, 32767, -32768, 32767, 0);
    send(3, -1, -1, 5, 5);
    send(CMD_HSPAN, -32768, 32767, 0, 0);
    send(CMD_HSPAN, 100, 50, 1, 0);
    send(CMD_HSPAN, 320, 400, 2, 0);
    send(CMD_VSPAN, 319, 0, -32768, 3);
    send(CMD_VSPAN, -1, 0, 10, 5);
    send(CMD_HSPAN, 7, 9, ROWS - 1, -1);
    send(CMD_VSPAN, 12, 0, ROWS - 3, 32767);
    for (int i = 0; i < 5; i++) send(CMD_DRAIN, -1, -1, -1, -1);
    // new edges during a pass, on rows behind the cursor
    send(CMD_HSPAN, 3, 4, 4, 0);
    send(CMD_HSPAN, 5, 6, 0, 0);
    for (int i = 0; i < 8; i++) send(CMD_DRAIN, 0, 0, 0, 0);

    while (sent < 1350) begin
      if ($urandom_range(9) < 8) shape();
      else send($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (ROWS + 10) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
